// ===== design/fms_pkg.sv =====
package fms_pkg;

    localparam int QLEN_W   = 4;
    localparam int QBYTES_W = 64;
    localparam int BYTE_W   = 8;
    localparam int SCORE_W  = 15;

    typedef logic [BYTE_W-1:0]         t_byte;
    typedef logic [QLEN_W-1:0]         t_qlen;
    typedef logic [QBYTES_W-1:0]       t_qbytes;
    typedef logic signed [SCORE_W-1:0] t_score;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SUBSEQ = 2'd1,
        KIND_SUBSTR = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef struct packed {
        t_score score;
        t_kind  kind;
    } t_result;

    typedef enum logic {
        CFG_QUERY_LEN   = 1'b0,
        CFG_QUERY_BYTES = 1'b1
    } t_cfg_idx;

    localparam t_byte CHAR_UP_A       = 8'h41;
    localparam t_byte CHAR_UP_Z       = 8'h5A;
    localparam t_byte CASE_OFFSET     = 8'h20;
    localparam t_byte CHAR_SPACE      = 8'h20;
    localparam t_byte CHAR_UNDERSCORE = 8'h5F;
    localparam t_byte CHAR_SLASH      = 8'h2F;

    // subsequence scoring
    localparam logic [8:0] HIT_POINTS  = 9'd10;
    localparam logic [8:0] WORD_POINTS = 9'd15;
    localparam logic [8:0] RUN_POINTS  = 9'd5;

    localparam int     SCORE_BASE  = 1000;
    localparam int     SCORE_FLOOR = -16384;
    localparam t_score SCORE_EMPTY = 15'sd1;
    localparam t_score SCORE_ZERO  = 15'sd0;

    function automatic t_byte to_lower(input t_byte c);
        t_byte r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic t_byte query_byte(input t_qbytes q, input logic [2:0] i);
        t_byte r;
        r = q[i*BYTE_W +: BYTE_W];
        return to_lower(r);
    endfunction

    function automatic logic is_separator(input t_byte c);
        return (c == CHAR_SPACE) || (c == CHAR_UNDERSCORE) || (c == CHAR_SLASH);
    endfunction

endpackage

// ===== design/fms_in_if.sv =====
interface fms_in_if;
    logic                valid;
    logic                ready;
    fms_pkg::t_byte      text_byte;
    logic                has_byte;
    logic                last;

    modport source (output valid, text_byte, has_byte, last, input ready);
    modport sink   (input valid, text_byte, has_byte, last, output ready);
endinterface

// ===== design/fms_out_if.sv =====
interface fms_out_if;
    logic                valid;
    logic                ready;
    fms_pkg::t_score     score;
    fms_pkg::t_kind      match_kind;

    modport source (output valid, score, match_kind, input ready);
    modport sink   (input valid, score, match_kind, output ready);
endinterface

// ===== design/fms_cell.sv =====
// One window slot: holds a lowercased text byte, passes it on at each shift,
// and compares the byte it is about to hold with its query byte.
module fms_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  fms_pkg::t_byte   i_byte,
    input  fms_pkg::t_qlen   i_qlen,
    input  fms_pkg::t_qbytes i_qbytes,
    output fms_pkg::t_byte   o_byte,
    output logic             o_hit
);

    fms_pkg::t_byte r_byte;
    fms_pkg::t_qlen v_sel;

    // slot IDX lines up with query byte qlen-1-IDX; unused slots always hit
    always_comb begin
        v_sel = i_qlen - fms_pkg::t_qlen'(IDX) - fms_pkg::t_qlen'(1);
        if (fms_pkg::t_qlen'(IDX) >= i_qlen) begin
            o_hit = 1'b1;
        end else begin
            o_hit = (i_byte == fms_pkg::query_byte(i_qbytes, v_sel[2:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== design/fms_track.sv =====
// Per-text state: window fill, position, substring latch, greedy subsequence.
// o_result is the result of the current item, valid when it carries last.
module fms_track #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_TEXT  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_done,
    input  fms_pkg::t_byte    i_byte,
    input  fms_pkg::t_qlen    i_qlen,
    input  fms_pkg::t_qbytes  i_qbytes,
    input  logic              i_win_hit,
    output fms_pkg::t_result  o_result
);

    localparam int FILL_W = $clog2(MAX_QUERY + 1);
    localparam int POS_W  = $clog2(MAX_TEXT + 1);
    localparam int SW     = (POS_W + 3 > 16) ? POS_W + 3 : 16;
    localparam logic signed [SW-1:0] FLOOR_W = SW'(fms_pkg::SCORE_FLOOR);
    localparam logic signed [SW-1:0] BASE_W  = SW'(fms_pkg::SCORE_BASE);

    logic [FILL_W-1:0] r_fill,   n_fill;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic              r_found,  n_found;
    logic [POS_W-1:0]  r_start,  n_start;
    logic [3:0]        r_cursor, n_cursor;
    logic [3:0]        r_run,    n_run;
    logic [8:0]        r_part,   n_part;
    logic              r_sep,    n_sep;

    logic [POS_W:0]         v_end;
    logic signed [SW-1:0]   v_wide;

    always_comb begin
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_found  = r_found;
        n_start  = r_start;
        n_cursor = r_cursor;
        n_run    = r_run;
        n_part   = r_part;
        n_sep    = r_sep;
        v_end    = {1'b0, r_pos} + (POS_W+1)'(1);

        if (i_take) begin
            if (r_fill < FILL_W'(MAX_QUERY)) begin
                n_fill = r_fill + FILL_W'(1);
            end
            if (!r_found && i_qlen != '0 && fms_pkg::t_qlen'(n_fill) >= i_qlen
                    && i_win_hit) begin
                n_found = 1'b1;
                if (v_end >= (POS_W+1)'(i_qlen)) begin
                    n_start = POS_W'(v_end - (POS_W+1)'(i_qlen));
                end else begin
                    n_start = '0;
                end
            end
            if (r_cursor < i_qlen) begin
                if (i_byte == fms_pkg::query_byte(i_qbytes, r_cursor[2:0])) begin
                    n_part   = r_part + fms_pkg::HIT_POINTS
                             + (r_sep ? fms_pkg::WORD_POINTS : 9'd0)
                             + 9'(r_run) * fms_pkg::RUN_POINTS;
                    n_run    = r_run + 4'd1;
                    n_cursor = r_cursor + 4'd1;
                end else begin
                    n_run = '0;
                end
            end
            n_sep = fms_pkg::is_separator(i_byte);
            if (r_pos < POS_W'(MAX_TEXT)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // substring score: 1000 - 2*start - length, floored
    always_comb begin
        v_wide = BASE_W - (SW'(n_start) << 1) - SW'(n_pos);
        if (v_wide < FLOOR_W) begin
            v_wide = FLOOR_W;
        end
    end

    always_comb begin
        if (i_qlen == '0) begin
            o_result.score = fms_pkg::SCORE_EMPTY;
            o_result.kind  = fms_pkg::KIND_EMPTY;
        end else if (n_found) begin
            o_result.score = fms_pkg::t_score'(v_wide);
            o_result.kind  = fms_pkg::KIND_SUBSTR;
        end else if (n_cursor >= i_qlen) begin
            o_result.score = fms_pkg::t_score'(n_part);
            o_result.kind  = fms_pkg::KIND_SUBSEQ;
        end else begin
            o_result.score = fms_pkg::SCORE_ZERO;
            o_result.kind  = fms_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_done) begin
            r_fill   <= '0;
            r_pos    <= '0;
            r_found  <= 1'b0;
            r_start  <= '0;
            r_cursor <= '0;
            r_run    <= '0;
            r_part   <= '0;
            r_sep    <= 1'b1;
        end else begin
            r_fill   <= n_fill;
            r_pos    <= n_pos;
            r_found  <= n_found;
            r_start  <= n_start;
            r_cursor <= n_cursor;
            r_run    <= n_run;
            r_part   <= n_part;
            r_sep    <= n_sep;
        end
    end

endmodule

// ===== design/fuzzy_match_scorer_core.sv =====
// Fuzzy match scorer. Streams one text byte per transfer on i_in and scores
// the text against a query of up to MAX_QUERY bytes (case-insensitive for
// A-Z). One result leaves on o_out for each input transfer with last set;
// has_byte=0 marks an item without a byte (e.g. an empty text). Throughput
// is one input transfer per clock: the query window is a chain of MAX_QUERY
// byte cells that shift and compare in the same cycle the byte arrives,
// and the subsequence score updates in that cycle too. A last item's result
// is registered into the output head, or into the skid entry while the head
// holds an untaken result; with these two entries behind the scorer, input
// is stalled only while both hold untaken results. Write query_len /
// query_bytes over the config port while no text is in flight.
module fuzzy_match_scorer_core #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_TEXT  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fms_in_if.sink             i_in,
    fms_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  fms_pkg::t_qbytes   i_cfg_data
);

    // configuration registers
    fms_pkg::t_qlen   r_qlen;
    fms_pkg::t_qbytes r_qbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen   <= '0;
            r_qbytes <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fms_pkg::CFG_QUERY_LEN) begin
                r_qlen <= i_cfg_data[fms_pkg::QLEN_W-1:0];
            end else begin
                r_qbytes <= i_cfg_data;
            end
        end
    end

    // lengths above MAX_QUERY act as MAX_QUERY
    fms_pkg::t_qlen qlen_act;
    assign qlen_act = (r_qlen > fms_pkg::t_qlen'(MAX_QUERY))
                    ? fms_pkg::t_qlen'(MAX_QUERY) : r_qlen;

    logic           in_xfer;
    logic           take;
    logic           done;
    fms_pkg::t_byte low_byte;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign take     = in_xfer && i_in.has_byte;
    assign done     = in_xfer && i_in.last;
    assign low_byte = fms_pkg::to_lower(i_in.text_byte);

    // window: cell 0 holds the newest byte
    fms_pkg::t_byte          cell_in  [MAX_QUERY];
    fms_pkg::t_byte          cell_out [MAX_QUERY];
    logic [MAX_QUERY-1:0]    cell_hit;

    for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = low_byte;
        end else begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        fms_cell #(.IDX(k)) u_cell (
            .i_clk    (i_clk),
            .i_shift  (take),
            .i_byte   (cell_in[k]),
            .i_qlen   (qlen_act),
            .i_qbytes (r_qbytes),
            .o_byte   (cell_out[k]),
            .o_hit    (cell_hit[k])
        );
    end

    fms_pkg::t_result item_res;

    fms_track #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_TEXT  (MAX_TEXT)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_done    (done),
        .i_byte    (low_byte),
        .i_qlen    (qlen_act),
        .i_qbytes  (r_qbytes),
        .i_win_hit (&cell_hit),
        .o_result  (item_res)
    );

    // two-entry result buffer: head drives o_out, skid catches overflow
    fms_pkg::t_result r_head, r_skid;
    logic             r_hv, r_sv;
    logic             pop;

    assign pop        = r_hv && o_out.ready;
    assign i_in.ready = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_head <= r_skid;
                r_sv   <= 1'b0;
            end else begin
                r_hv   <= done;
                r_head <= item_res;
            end
        end else if (done) begin
            if (!r_hv) begin
                r_hv   <= 1'b1;
                r_head <= item_res;
            end else begin
                r_sv   <= 1'b1;
                r_skid <= item_res;
            end
        end
    end

    assign o_out.valid      = r_hv;
    assign o_out.score      = r_head.score;
    assign o_out.match_kind = r_head.kind;

    // skid is only ever filled behind a full head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_hv)
        else $error("skid entry valid with empty head");

    // a result arriving at a stalled full head lands in the skid
    a_overflow_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_hv && !o_out.ready) |=> r_sv)
        else $error("result lost while head stalled");

    a_empty_scores_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.match_kind == fms_pkg::KIND_EMPTY)
            |-> o_out.score == fms_pkg::SCORE_EMPTY)
        else $error("empty query result not scored 1");

    a_none_scores_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.match_kind == fms_pkg::KIND_NONE)
            |-> o_out.score == fms_pkg::SCORE_ZERO)
        else $error("unmatched result with nonzero score");

    a_subseq_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.match_kind == fms_pkg::KIND_SUBSEQ)
            |-> o_out.score > fms_pkg::SCORE_ZERO)
        else $error("subsequence result without points");

endmodule

// ===== bench/fuzzy_match_scorer_core_test.sv =====
module fuzzy_match_scorer_core_test;

    // Query slots and text cap follow the block's default parameters.
    localparam int QUERY_SLOTS  = 8;
    localparam int TEXT_CAP     = 4096;
    localparam int RANDOM_BYTES = 1850;
    // Longest legal quiet stretch is one sender gap plus one sink stall
    // (each one idle_len draw) or a settle pause; this is far above that.
    localparam int STALL_LIMIT  = 1000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_idx;
    fms_pkg::t_qbytes i_cfg_data;

    fms_in_if  in_ch ();
    fms_out_if out_ch ();

    fuzzy_match_scorer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoring predictor: a private copy of the query registers and the
    // per-text state, advanced on each accepted transfer with a byte or last.
    // ------------------------------------------------------------------
    fms_pkg::t_qlen   cfg_len;
    fms_pkg::t_qbytes cfg_query;

    fms_pkg::t_byte win_bytes [QUERY_SLOTS];   // newest lowercased byte at index 0
    int    win_fill;
    int    text_pos;                  // saturates at TEXT_CAP
    bit    sub_found;
    int    sub_start;
    int    q_cursor;                  // next query byte for the subsequence
    int    run_len;
    int    subseq_score;
    bit    after_sep;                 // start of text counts as a word start

    fms_pkg::t_result pending_scores [$];  // scores owed by the block, oldest first
    fms_pkg::t_byte   text_buf [$];        // text being assembled for sending

    int fail_count   = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    bit calm;                         // phase with no gaps on either side

    function automatic fms_pkg::t_byte fold_case(input fms_pkg::t_byte c);
        return (c inside {[fms_pkg::CHAR_UP_A:fms_pkg::CHAR_UP_Z]})
             ? (c | fms_pkg::CASE_OFFSET) : c;
    endfunction

    function automatic int used_len();
        return (cfg_len > QUERY_SLOTS) ? QUERY_SLOTS : int'(cfg_len);
    endfunction

    function automatic fms_pkg::t_byte query_char(input int i);
        return fold_case(cfg_query[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W]);
    endfunction

    function automatic void append_text(input fms_pkg::t_byte b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void owe_score(input fms_pkg::t_result r);
        pending_scores.insert(pending_scores.size(), r);
    endfunction

    function automatic void forget_text();
        foreach (win_bytes[k]) win_bytes[k] = '0;
        win_fill     = 0;
        text_pos     = 0;
        sub_found    = 1'b0;
        sub_start    = 0;
        q_cursor     = 0;
        run_len      = 0;
        subseq_score = 0;
        after_sep    = 1'b1;
    endfunction

    function automatic void absorb_byte(input fms_pkg::t_byte raw);
        int    qlen;
        int    idx;
        int    k;
        bit    hit;
        fms_pkg::t_byte c;
        qlen = used_len();
        c    = fold_case(raw);
        idx  = text_pos;

        for (k = QUERY_SLOTS - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = c;
        if (win_fill < QUERY_SLOTS) win_fill++;

        // Contiguous match: window (newest first) against query reversed.
        // Only the first occurrence counts.
        if (!sub_found && qlen > 0 && win_fill >= qlen) begin
            hit = 1'b1;
            for (k = 0; k < qlen; k++) begin
                if (win_bytes[k] != query_char(qlen - 1 - k)) hit = 1'b0;
            end
            if (hit) begin
                sub_found = 1'b1;
                sub_start = (idx + 1 >= qlen) ? idx + 1 - qlen : 0;
            end
        end

        // Greedy subsequence: a miss breaks the run but keeps the cursor.
        if (q_cursor < qlen) begin
            if (c == query_char(q_cursor)) begin
                subseq_score += int'(fms_pkg::HIT_POINTS)
                              + (after_sep ? int'(fms_pkg::WORD_POINTS) : 0)
                              + int'(fms_pkg::RUN_POINTS) * run_len;
                run_len++;
                q_cursor++;
            end else begin
                run_len = 0;
            end
        end

        after_sep = (c == fms_pkg::CHAR_SPACE) || (c == fms_pkg::CHAR_UNDERSCORE)
                 || (c == fms_pkg::CHAR_SLASH);
        if (text_pos < TEXT_CAP) text_pos++;
    endfunction

    function automatic fms_pkg::t_result text_score();
        int      qlen;
        int      s;
        fms_pkg::t_result r;
        qlen = used_len();
        if (qlen == 0) begin
            s      = 1;
            r.kind = fms_pkg::KIND_EMPTY;
        end else if (sub_found) begin
            s = fms_pkg::SCORE_BASE - 2 * sub_start - text_pos;
            if (s < fms_pkg::SCORE_FLOOR) s = fms_pkg::SCORE_FLOOR;
            r.kind = fms_pkg::KIND_SUBSTR;
        end else if (q_cursor >= qlen) begin
            s      = subseq_score;
            r.kind = fms_pkg::KIND_SUBSEQ;
        end else begin
            s      = 0;
            r.kind = fms_pkg::KIND_NONE;
        end
        r.score = s[fms_pkg::SCORE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int short_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    endfunction

    function automatic fms_pkg::t_byte mixed_case(input fms_pkg::t_byte c);
        if (c inside {["a":"z"]} && $urandom_range(0, 1)) return c - fms_pkg::CASE_OFFSET;
        return c;
    endfunction

    function automatic fms_pkg::t_byte pick_separator();
        case ($urandom_range(0, 2))
            0: return fms_pkg::CHAR_SPACE;
            1: return fms_pkg::CHAR_UNDERSCORE;
            default: return fms_pkg::CHAR_SLASH;
        endcase
    endfunction

    // Filler biased toward query bytes and word separators so that partial
    // matches, broken runs and word starts all show up.
    function automatic fms_pkg::t_byte noise_byte();
        int qlen;
        int r;
        qlen = used_len();
        r    = $urandom_range(0, 9);
        if (r < 4 && qlen > 0) return mixed_case(query_char($urandom_range(0, qlen - 1)));
        if (r < 6) return pick_separator();
        if (r < 9) return mixed_case(fms_pkg::t_byte'("a" + $urandom_range(0, 5)));
        return fms_pkg::t_byte'($urandom_range(0, 255));
    endfunction

    // Builds one text into text_buf: mostly well-formed (embedded query or
    // scattered subsequence), the rest noise or fully random bytes.
    function automatic void fill_text();
        int qlen;
        int mode;
        int n;
        int i;
        qlen = used_len();
        mode = $urandom_range(0, 9);
        text_buf.delete();
        if (mode < 4) begin
            repeat (short_len()) append_text(noise_byte());
            for (i = 0; i < qlen; i++) append_text(mixed_case(query_char(i)));
            repeat (short_len()) append_text(noise_byte());
        end else if (mode < 7) begin
            for (i = 0; i < qlen; i++) begin
                repeat ($urandom_range(0, 2)) append_text(noise_byte());
                // occasionally drop a query byte: broken subsequence
                if ($urandom_range(0, 7) != 0) append_text(mixed_case(query_char(i)));
            end
            repeat (short_len()) append_text(noise_byte());
        end else if (mode < 9) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
            repeat (n) append_text(noise_byte());
        end else begin
            repeat ($urandom_range(0, 20))
                append_text(fms_pkg::t_byte'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void load_text(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) append_text(fms_pkg::t_byte'(s[i]));
    endfunction

    function automatic fms_pkg::t_qbytes pack_query(input string s,
                                                    input fms_pkg::t_byte pad);
        fms_pkg::t_qbytes q;
        int      i;
        for (i = 0; i < QUERY_SLOTS; i++) begin
            q[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W] =
                (i < s.len()) ? fms_pkg::t_byte'(s[i]) : pad;
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven at the falling edge; transfers are
    // judged at the rising edge. Tasks start and end on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input fms_pkg::t_byte b, input bit has, input bit fin);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.text_byte = b;
        in_ch.has_byte  = has;
        in_ch.last      = fin;
        in_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // transfer taken at this edge
        if (has) begin
            absorb_byte(b);
            bytes_sent++;
        end
        if (fin) begin
            owe_score(text_score());
            forget_text();
        end
        @(negedge i_clk);
    endtask

    // Sends text_buf. With jitter, byte-less items are sprinkled in and the
    // text is sometimes closed by a byte-less last item.
    task automatic send_text(input bit jitter);
        int i;
        bit tail;
        tail = jitter && ($urandom_range(0, 7) == 0);
        if (text_buf.size() == 0) begin
            send_item(fms_pkg::t_byte'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (i = 0; i < text_buf.size(); i++) begin
                if (jitter && $urandom_range(0, 9) == 0) begin
                    send_item(fms_pkg::t_byte'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                send_item(text_buf[i], 1'b1, (i == text_buf.size() - 1) && !tail);
            end
            if (tail) send_item(fms_pkg::t_byte'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Drain: hold the sender until every owed score is back, then let the
    // block idle before touching the registers.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending_scores.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input fms_pkg::t_cfg_idx idx, input fms_pkg::t_qbytes val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == fms_pkg::CFG_QUERY_LEN) cfg_len = val[fms_pkg::QLEN_W-1:0];
        else cfg_query = val;
    endtask

    task automatic set_query(input string s, input int len, input fms_pkg::t_byte pad);
        settle();
        write_reg(fms_pkg::CFG_QUERY_BYTES, pack_query(s, pad));
        write_reg(fms_pkg::CFG_QUERY_LEN, fms_pkg::t_qbytes'(len));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Query length 0 after reset: every text scores as empty query, the
    // byte-less empty text included; stale query bytes must not matter.
    task automatic test_empty_query();
        load_text("");
        send_text(1'b0);
        settle();
        write_reg(fms_pkg::CFG_QUERY_BYTES, pack_query("xyz", 8'h00));
        load_text("Ab");
        send_text(1'b0);
        settle();
    endtask

    // Contiguous hit past position 0, case folded on both sides.
    task automatic test_substring();
        set_query("aBc", 3, 8'hFF);
        load_text("xABC");
        send_text(1'b0);
        settle();
    endtask

    // Scattered hits, each at a word start (text start, after '_', after '/'), a byte-less
    // item mid-text, then an empty text against a real query.
    task automatic test_subsequence();
        send_item("a", 1'b1, 1'b0);
        send_item("_", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item("B", 1'b1, 1'b0);
        send_item("/", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        settle();
    endtask

    // Length register above the slot count is clamped to all eight slots.
    task automatic test_long_query();
        set_query("", 15, 8'hFF);
        repeat (QUERY_SLOTS - 1) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        settle();
    endtask

    task automatic new_random_query();
        fms_pkg::t_qbytes q;
        fms_pkg::t_qbytes len_word;
        int      i;
        int      r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            q = '0;
        end else if (r < 3) begin
            q = '1;
        end else if (r < 5) begin
            q = {$urandom(), $urandom()};
        end else begin
            for (i = 0; i < QUERY_SLOTS; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: q[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W] =
                        fms_pkg::t_byte'("a" + $urandom_range(0, 5));
                    6: q[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W] =
                        fms_pkg::t_byte'("A" + $urandom_range(0, 5));
                    7: q[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W] = pick_separator();
                    default: q[i*fms_pkg::BYTE_W +: fms_pkg::BYTE_W] =
                        fms_pkg::t_byte'($urandom_range(0, 255));
                endcase
            end
        end

        // upper bits of the length write are junk the block must ignore
        len_word = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : '0;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            len_word[fms_pkg::QLEN_W-1:0] = '0;
        end else if (r < 5) begin
            len_word[fms_pkg::QLEN_W-1:0] = fms_pkg::t_qlen'(QUERY_SLOTS);
        end else if (r < 6) begin
            len_word[fms_pkg::QLEN_W-1:0] =
                fms_pkg::t_qlen'($urandom_range(QUERY_SLOTS + 1, 15));
        end else begin
            len_word[fms_pkg::QLEN_W-1:0] =
                fms_pkg::t_qlen'($urandom_range(1, QUERY_SLOTS - 1));
        end

        settle();
        if ($urandom_range(0, 4) != 0) write_reg(fms_pkg::CFG_QUERY_BYTES, q);
        write_reg(fms_pkg::CFG_QUERY_LEN, len_word);
    endtask

    task automatic test_random_texts();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 3) == 0);
            new_random_query();
            repeat ($urandom_range(3, 10)) begin
                fill_text();
                send_text(1'b1);
                if ($urandom_range(0, 29) == 0) settle();
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random backpressure, bursts of stalls, calm stretches.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                out_ch.ready = 1'b1;
            end else begin
                hold = idle_len();
                out_ch.ready = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
        end
    end

    // Each result transfer is matched against the oldest owed score.
    always @(posedge i_clk) begin : score_check
        fms_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_scores.size() == 0) begin
                $error("unexpected result: score %0d kind %0d",
                       out_ch.score, out_ch.match_kind);
                fail_count++;
            end else begin
                want = pending_scores.pop_front();
                if (out_ch.score !== want.score) begin
                    $error("score: expected %0d, got %0d", want.score, out_ch.score);
                    fail_count++;
                end
                if (out_ch.match_kind !== want.kind) begin
                    $error("match_kind: expected %0d, got %0d", want.kind, out_ch.match_kind);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL fuzzy_match_scorer_core");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = fms_pkg::CFG_QUERY_LEN;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = '0;
        in_ch.has_byte  = 1'b0;
        in_ch.last      = 1'b0;
        calm            = 1'b0;
        cfg_len         = '0;
        cfg_query       = '0;
        forget_text();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_query();
        test_substring();
        test_subsequence();
        test_byte_extremes();
        test_long_query();
        test_random_texts();

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS fuzzy_match_scorer_core");
        end else begin
            $display("FAIL fuzzy_match_scorer_core");
        end
        $finish;
    end

endmodule
